### design/assert_macros.svh
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on clk_i, held off while rst_ni is low
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same, checked during reset too
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/lsrc_pkg.sv
// ----------------------------------------------------------------------------
// lsrc_pkg
// Shared widths, types and constants of the linear sample rate converter.
// ----------------------------------------------------------------------------
package lsrc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned StepW   = 23;
  localparam int unsigned RunMax  = 64;
  localparam int unsigned RunCntW = 7;

  localparam logic [StepW-1:0] CfgStepReset = 23'd65536;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [StepW-1:0]          step_t;
  typedef logic [RunCntW-1:0]        run_cnt_t;

endpackage

### design/lsrc_interp.sv
// ----------------------------------------------------------------------------
// lsrc_interp
// Multiply-add unit: prev + (next - prev) * phase, truncated toward zero.
// ----------------------------------------------------------------------------
module lsrc_interp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  lsrc_pkg::sample_t     prev_i,
  input  lsrc_pkg::sample_t     next_i,
  input  logic [FRAC_BITS-1:0]  phase_i,
  output lsrc_pkg::sample_t     sample_o
);
  import lsrc_pkg::*;

  localparam int unsigned ProdW  = SampleW + FRAC_BITS + 2;
  localparam int unsigned TotalW = SampleW + FRAC_BITS + 3;

  logic signed [SampleW:0]    diff;
  logic signed [FRAC_BITS:0]  phase_s;
  logic signed [ProdW-1:0]    prod;
  logic signed [TotalW-1:0]   base;
  logic signed [TotalW-1:0]   total;
  logic signed [TotalW-1:0]   quot;
  logic                       round_up;

  always_comb begin
    diff     = {next_i[SampleW-1], next_i} - {prev_i[SampleW-1], prev_i};
    phase_s  = {1'b0, phase_i};
    prod     = ProdW'(diff) * ProdW'(phase_s);
    base     = TotalW'(prev_i) <<< FRAC_BITS;
    total    = base + TotalW'(prod);
    quot     = total >>> FRAC_BITS;
    // arithmetic shift floors, so nudge negatives with a remainder back toward zero
    round_up = total[TotalW-1] && (|total[FRAC_BITS-1:0]);
    sample_o = SampleW'(quot + TotalW'(round_up));
  end

endmodule

### design/linear_sample_rate_converter.sv
// ----------------------------------------------------------------------------
// linear_sample_rate_converter
// Resamples 16-bit mono audio by linear interpolation between neighbours.
// ----------------------------------------------------------------------------
// One input sample is taken at a time. With a step of exactly one it comes
// straight back as a single result in the next cycle and the block is ready
// again once that result register is free. The first sample after reset is
// only stored. Otherwise the block takes the sample, then steps the phase
// through the multiply-add unit, one result per phase increment while the
// output side keeps up, and returns to idle once it sees the phase reach
// one. A run holds up to 64 results at the highest upsampling ratio, and
// none when downsampling skips a sample. The step register may be written
// at any time the block is idle; the step taken from it is clamped to the
// range 1/64..64.
// ----------------------------------------------------------------------------
module linear_sample_rate_converter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // step register write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  lsrc_pkg::step_t       cfg_data_i,
  // input samples
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [15:0]           s_axis_tdata_i,   // [15:0] sample_in
  // output samples
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [15:0]           m_axis_tdata_o,   // [15:0] sample_out
  output logic                  m_axis_tlast_o    // last_of_run
);
  import lsrc_pkg::*;

  localparam int unsigned PhW  = FRAC_BITS + 7;
  localparam int unsigned CmpW = (FRAC_BITS + 7 > StepW) ? FRAC_BITS + 7 : StepW;

  localparam logic [CmpW-1:0] OneCmp  = CmpW'(1) << FRAC_BITS;
  localparam logic [CmpW-1:0] StepMin = CmpW'(1) << (FRAC_BITS - 6);
  localparam logic [CmpW-1:0] StepMax = CmpW'(1) << (FRAC_BITS + 6);
  localparam logic [PhW-1:0]  OnePh   = PhW'(1) << FRAC_BITS;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  localparam logic [1:0] PrimeNone = 2'd0;
  localparam logic [1:0] PrimeHalf = 2'd1;
  localparam logic [1:0] PrimeFull = 2'd2;

  localparam run_cnt_t RunLimit = RunCntW'(RunMax);
  localparam run_cnt_t RunLast  = RunCntW'(RunMax - 1);

  logic             state_q, state_d;
  logic [1:0]       prime_q, prime_d;
  step_t            cfg_step_q;
  sample_t          prev_q, prev_d;
  sample_t          next_q, next_d;
  logic [PhW-1:0]   phase_q, phase_d;
  logic [PhW-1:0]   step_q, step_d;
  run_cnt_t         cnt_q, cnt_d;

  logic             out_valid_q;
  sample_t          out_data_q;
  logic             out_last_q;

  logic             out_free;
  logic             in_acc;
  logic             pass_through;
  logic [CmpW-1:0]  step_ext;
  logic [CmpW-1:0]  step_clamp;
  logic             phase_ge_one;
  logic [PhW-1:0]   phase_sum;
  sample_t          sample_in;
  sample_t          interp_val;
  logic             out_load;
  sample_t          out_data_d;
  logic             out_last_d;

  lsrc_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .prev_i   (prev_q),
    .next_i   (next_q),
    .phase_i  (phase_q[FRAC_BITS-1:0]),
    .sample_o (interp_val)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_step_q <= CfgStepReset;
    end else if (cfg_valid_i) begin
      cfg_step_q <= cfg_data_i;
    end
  end

  always_comb begin
    out_free        = !out_valid_q || m_axis_tready_i;
    s_axis_tready_o = (state_q == StIdle) && out_free;
    in_acc          = s_axis_tvalid_i && s_axis_tready_o;
    sample_in       = sample_t'(s_axis_tdata_i);

    step_ext     = CmpW'(cfg_step_q);
    pass_through = (step_ext == OneCmp);
    if (step_ext < StepMin) begin
      step_clamp = StepMin;
    end else if (step_ext > StepMax) begin
      step_clamp = StepMax;
    end else begin
      step_clamp = step_ext;
    end

    phase_ge_one = |phase_q[PhW-1:FRAC_BITS];
    phase_sum    = phase_q + step_q;

    state_d    = state_q;
    prime_d    = prime_q;
    prev_d     = prev_q;
    next_d     = next_q;
    phase_d    = phase_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    out_load   = 1'b0;
    out_data_d = interp_val;
    out_last_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (pass_through) begin
            out_load   = 1'b1;
            out_data_d = sample_in;
            out_last_d = 1'b1;
          end else begin
            step_d = PhW'(step_clamp);
            cnt_d  = '0;
            if (prime_q == PrimeNone) begin
              prev_d  = sample_in;
              prime_d = PrimeHalf;
            end else if (prime_q == PrimeHalf) begin
              next_d  = sample_in;
              prime_d = PrimeFull;
              phase_d = '0;
              state_d = StRun;
            end else begin
              if (phase_ge_one) begin
                prev_d  = next_q;
                next_d  = sample_in;
                phase_d = phase_q - OnePh;
              end
              state_d = StRun;
            end
          end
        end
      end
      StRun: begin
        if (phase_ge_one) begin
          state_d = StIdle;
        end else if (cnt_q < RunLimit) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_last_d = (phase_sum >= OnePh) || (cnt_q == RunLast);
            phase_d    = phase_sum;
            cnt_d      = cnt_q + 1'b1;
          end
        end else begin
          // run is full: keep stepping the phase without results
          phase_d = phase_sum;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prime_q     <= PrimeNone;
      prev_q      <= '0;
      next_q      <= '0;
      phase_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prime_q <= prime_d;
      prev_q  <= prev_d;
      next_q  <= next_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    if (out_load) begin
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  `include "assert_macros.svh"

  `ASSERT_CLKD(a_run_cnt_bound, cnt_q <= RunLimit, "run counter past its limit")
  `ASSERT_ALWAYS(a_prime_code, !rst_ni || (prime_q <= PrimeFull), "priming count took an unused code")
  `ASSERT_CLKD(a_run_primed, (state_q == StRun) |-> (prime_q == PrimeFull), "run while not primed")
  `ASSERT_CLKD(a_no_overwrite, (s_axis_tvalid_i && s_axis_tready_o) |-> out_free,
               "input transaction while a result is still held")

endmodule
